// File: rtl/lkvc_pkg.sv
// shared types and constants for the lru key/value cache
package lkvc_pkg;

    // field widths
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CFG_W = 5;

    // command codes
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    // value returned by a get that misses
    localparam logic [VAL_W-1:0] MISS_VALUE = '1;

    // capacity register value after reset
    localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_UPDATE
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic lookup;
        logic update;
    } t_ctrl_cmd;

endpackage

// File: rtl/lru_key_value_cache_core.sv
// top level of the lru key/value cache
//
// Fully associative key/value store with least-recently-used replacement.
// Command channel: an item (i_command, i_lookup_key, i_write_value) transfers
// at a rising edge with start high and busy low. i_command selects get or put.
// Result channel: o_done is high for exactly one cycle with o_found,
// o_read_value, o_evicted and o_evicted_key; the receiver cannot stall it and
// the result is taken at the edge that ends that cycle.
// Sequence: the result strobe rises in the same cycle that busy falls, and a new
// item is taken only while busy is low, so one item finishes before the next. The three
// steps are capture, parallel key compare with entry memory read, and the
// rank, memory and result update.
// Configuration: i_cfg_data transfers into the capacity register when
// i_cfg_valid and o_cfg_ready are high; ready is high while the block is idle.
// Capacity 0 acts as 1 and values above ENTRIES act as ENTRIES.
// Reset (synchronous, active low) empties the store and sets capacity to 16;
// no clearing pass is needed, start may be issued right after reset.
module lru_key_value_cache_core
    import lkvc_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             i_command,
    input  logic [KEY_W-1:0] i_lookup_key,
    input  logic [VAL_W-1:0] i_write_value,
    output logic             o_done,
    output logic             o_found,
    output logic [VAL_W-1:0] o_read_value,
    output logic             o_evicted,
    output logic [KEY_W-1:0] o_evicted_key,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    t_ctrl_cmd cmd;
    logic      idle;

    // sequencing
    lkvc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_idle  (idle),
        .o_cmd   (cmd)
    );

    // storage and result
    lkvc_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg_we      (i_cfg_valid && idle),
        .i_cfg_data    (i_cfg_data),
        .i_command     (i_command),
        .i_lookup_key  (i_lookup_key),
        .i_write_value (i_write_value),
        .o_done        (o_done),
        .o_found       (o_found),
        .o_read_value  (o_read_value),
        .o_evicted     (o_evicted),
        .o_evicted_key (o_evicted_key)
    );

    assign o_cfg_ready = idle;

endmodule

// File: rtl/lkvc_ctrl.sv
// controller state machine sequencing capture, lookup and update
module lkvc_ctrl
    import lkvc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    output logic      o_idle,
    output t_ctrl_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: n_state = S_UPDATE;
            S_UPDATE: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd  = '0;
        busy   = 1'b1;
        o_idle = 1'b0;
        case (r_state)
            S_IDLE: begin
                busy        = 1'b0;
                o_idle      = 1'b1;
                o_cmd.capture = start;
            end
            S_LOOKUP: o_cmd.lookup = 1'b1;
            S_UPDATE: o_cmd.update = 1'b1;
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// File: rtl/lkvc_datapath.sv
// key lanes, recency ranks, entry memory and result registers
module lkvc_datapath
    import lkvc_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_ctrl_cmd          i_cmd,
    input  logic               i_cfg_we,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic               i_command,
    input  logic [KEY_W-1:0]   i_lookup_key,
    input  logic [VAL_W-1:0]   i_write_value,
    output logic               o_done,
    output logic               o_found,
    output logic [VAL_W-1:0]   o_read_value,
    output logic               o_evicted,
    output logic [KEY_W-1:0]   o_evicted_key
);

    localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SLOT_W = RANK_W;
    localparam int OCC_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (OCC_W > CFG_W) ? OCC_W : CFG_W;

    // captured item
    logic               r_cmd;
    logic [KEY_W-1:0]   r_key;
    logic [VAL_W-1:0]   r_wval;

    // configuration
    logic [CFG_W-1:0]   r_cap;

    // store state
    logic [ENTRIES-1:0] r_valid;
    logic [RANK_W-1:0]  r_rank     [ENTRIES];
    logic [KEY_W-1:0]   r_lane_key [ENTRIES];
    logic [OCC_W-1:0]   r_occ;
    logic [KEY_W+VAL_W-1:0] mem    [ENTRIES];
    logic [KEY_W+VAL_W-1:0] r_rd_data;

    // lookup results
    logic               r_hit;
    logic               r_full;
    logic [SLOT_W-1:0]  r_slot;
    logic [OCC_W-1:0]   r_old_rank;

    // result registers
    logic               r_done;
    logic               r_found;
    logic [VAL_W-1:0]   r_read_value;
    logic               r_evicted;
    logic [KEY_W-1:0]   r_evicted_key;

    // combinational lookup
    logic [ENTRIES-1:0] hit_vec;
    logic [ENTRIES-1:0] victim_vec;
    logic [SLOT_W-1:0]  hit_idx;
    logic [SLOT_W-1:0]  victim_idx;
    logic [OCC_W-1:0]   hit_rank;
    logic [CMP_W-1:0]   cap_eff;
    logic               full;
    logic [SLOT_W-1:0]  n_slot;
    logic [OCC_W-1:0]   n_old_rank;
    logic               upd_ranks;
    logic               put_miss;
    logic               do_insert;

    // effective capacity, saturated to 1..ENTRIES
    always_comb begin
        if (r_cap == '0) begin
            cap_eff = CMP_W'(1);
        end else if (CMP_W'(r_cap) > CMP_W'(ENTRIES)) begin
            cap_eff = CMP_W'(ENTRIES);
        end else begin
            cap_eff = CMP_W'(r_cap);
        end
    end

    assign full = CMP_W'(r_occ) >= cap_eff;

    // parallel key compare and least recent lane select
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            hit_vec[i]    = r_valid[i] && (r_lane_key[i] == r_key);
            victim_vec[i] = r_valid[i] && (OCC_W'(r_rank[i]) == (r_occ - OCC_W'(1)));
        end
    end

    // one-hot to index, valid keys are unique so at most one lane matches
    always_comb begin
        hit_idx    = '0;
        victim_idx = '0;
        hit_rank   = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            hit_idx    = hit_idx    | (hit_vec[i]    ? SLOT_W'(i) : '0);
            victim_idx = victim_idx | (victim_vec[i] ? SLOT_W'(i) : '0);
            hit_rank   = hit_rank   | (hit_vec[i]    ? OCC_W'(r_rank[i]) : '0);
        end
    end

    // slot and promotion threshold for this item
    always_comb begin
        if (|hit_vec) begin
            n_slot     = hit_idx;
            n_old_rank = hit_rank;
        end else if (full) begin
            n_slot     = victim_idx;
            n_old_rank = r_occ - OCC_W'(1);
        end else begin
            n_slot     = r_occ[SLOT_W-1:0];
            n_old_rank = r_occ;
        end
    end

    assign put_miss  = (r_cmd == CMD_PUT) && !r_hit;
    assign upd_ranks = i_cmd.update && (r_hit || (r_cmd == CMD_PUT));
    assign do_insert = i_cmd.update && put_miss && !r_full;

    // item capture and lookup registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd  <= i_command;
            r_key  <= i_lookup_key;
            r_wval <= i_write_value;
        end
        if (i_cmd.lookup) begin
            r_hit      <= |hit_vec;
            r_full     <= full;
            r_slot     <= n_slot;
            r_old_rank <= n_old_rank;
        end
    end

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_data;
        end
    end

    // entry memory, one write port and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.update && (r_cmd == CMD_PUT)) begin
            mem[r_slot] <= {r_key, r_wval};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_rd_data <= mem[n_slot];
        end
    end

    // valid bits, ranks and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_occ   <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            if (upd_ranks) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (SLOT_W'(i) == r_slot) begin
                        r_rank[i] <= '0;
                    end else if (r_valid[i] && (OCC_W'(r_rank[i]) < r_old_rank)) begin
                        r_rank[i] <= r_rank[i] + RANK_W'(1);
                    end
                end
            end
            if (do_insert) begin
                r_valid[r_slot] <= 1'b1;
                r_occ           <= r_occ + OCC_W'(1);
            end
        end
    end

    // key lanes written on put miss
    always_ff @(posedge i_clk) begin
        if (i_cmd.update && put_miss) begin
            r_lane_key[r_slot] <= r_key;
        end
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.update;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_found   <= r_hit;
            r_evicted <= put_miss && r_full;
            if (r_cmd == CMD_GET) begin
                r_read_value <= r_hit ? r_rd_data[VAL_W-1:0] : MISS_VALUE;
            end else begin
                r_read_value <= '0;
            end
            if (put_miss && r_full) begin
                r_evicted_key <= r_rd_data[KEY_W+VAL_W-1:VAL_W];
            end else begin
                r_evicted_key <= '0;
            end
        end
    end

    assign o_done        = r_done;
    assign o_found       = r_found;
    assign o_read_value  = r_read_value;
    assign o_evicted     = r_evicted;
    assign o_evicted_key = r_evicted_key;

    // occupancy never exceeds the store
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        OCC_W'(r_occ) <= OCC_W'(ENTRIES))
        else $error("occupancy beyond entry count");

    // at most one lane matches a key
    a_hit_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.lookup |-> $onehot0(hit_vec))
        else $error("key present in more than one lane");

    // a hit never evicts
    a_no_evict_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_found && o_evicted))
        else $error("eviction reported on a hit");

    // an eviction never comes from an empty store
    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.update && put_miss && r_full) |-> (r_occ != '0))
        else $error("eviction from an empty store");

endmodule
